// ===== design/utf8ca_pkg.sv =====
package utf8ca_pkg;

  localparam int unsigned MaxCharBytes = 4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LEAD = 2'd1;
  localparam logic [1:0] ST_BAD_CONT = 2'd2;

  // one assembled character as it leaves the block
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [2:0] length;
    logic [1:0] status;
  } result_t;

  // open character: expected_length of zero means none is open
  typedef struct packed {
    logic [MaxCharBytes-1:0][7:0] collected;
    logic [2:0]                   expected_length;
    logic [2:0]                   bytes_seen;
  } asm_state_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    casez (b)
      8'b0???????: len = 3'd1;
      8'b110?????: len = 3'd2;
      8'b1110????: len = 3'd3;
      8'b11110???: len = 3'd4;
      default:     len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

endpackage

// ===== design/utf8ca_step.sv =====
module utf8ca_step import utf8ca_pkg::*; (
  input  asm_state_t cur,
  input  logic [7:0] in_byte,
  output asm_state_t nxt,
  output logic       res_valid,
  output result_t    res
);

  logic [2:0]                   lead_len;
  logic [MaxCharBytes-1:0][7:0] bytes;
  logic [2:0]                   seen;
  logic [2:0]                   exp_len;
  logic                         bad_cont;

  always_comb begin
    lead_len  = lead_length(in_byte);
    bytes     = cur.collected;
    seen      = cur.bytes_seen;
    exp_len   = cur.expected_length;
    nxt       = cur;
    res_valid = 1'b0;
    res       = '0;
    bad_cont  = 1'b0;

    if (cur.expected_length == 3'd0) begin
      bytes    = '0;
      bytes[0] = in_byte;
      seen     = 3'd1;
      exp_len  = lead_len;
    end else begin
      bytes[cur.bytes_seen[1:0]] = in_byte;
      seen = cur.bytes_seen + 3'd1;
    end

    // bytes past the open length are still zero, so only 1..3 need a mask
    for (int i = 1; i < MaxCharBytes; i++) begin
      if (3'(i) < exp_len && !is_cont(bytes[i])) begin
        bad_cont = 1'b1;
      end
    end

    if (cur.expected_length == 3'd0 && lead_len == 3'd0) begin
      res_valid  = 1'b1;
      res.status = ST_BAD_LEAD;
      nxt        = '0;
    end else if (seen >= exp_len) begin
      res_valid  = 1'b1;
      res.byte0  = bytes[0];
      res.byte1  = bytes[1];
      res.byte2  = bytes[2];
      res.byte3  = bytes[3];
      res.length = exp_len;
      res.status = bad_cont ? ST_BAD_CONT : ST_OK;
      nxt        = '0;
    end else begin
      nxt.collected       = bytes;
      nxt.bytes_seen      = seen;
      nxt.expected_length = exp_len;
    end
  end

endmodule

// ===== design/utf8ca_skid.sv =====
module utf8ca_skid import utf8ca_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;
  logic    pop;

  assign pop       = main_valid && !out_stall;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign full      = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ===== design/utf8_char_assembler.sv =====
// UTF-8 character assembler. Takes one raw byte per word on the input
// channel and returns one word per complete character: its bytes (unused
// ones zero), its length and a status (ok, bad lead byte, bad continuation
// byte). A bad lead byte gives its error word at once; a bad continuation
// byte is reported when the character's full length has arrived. Each byte
// is handled in the cycle it is accepted, so one byte is taken every cycle
// unless the input stalls; a character's word is registered in the output
// buffer before it appears. The two-entry buffer lets input continue while a
// result waits; input stalls only when both entries are held.
module utf8_char_assembler import utf8ca_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] char_byte0,
  output logic [7:0] char_byte1,
  output logic [7:0] char_byte2,
  output logic [7:0] char_byte3,
  output logic [2:0] char_length,
  output logic [1:0] status
);

  asm_state_t state;
  asm_state_t state_next;
  logic       res_valid;
  result_t    res;
  result_t    out_data;
  logic       buf_full;
  logic       accept;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  utf8ca_step u_step (
    .cur       (state),
    .in_byte   (in_byte),
    .nxt       (state_next),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  utf8ca_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign char_byte0  = out_data.byte0;
  assign char_byte1  = out_data.byte1;
  assign char_byte2  = out_data.byte2;
  assign char_byte3  = out_data.byte3;
  assign char_length = out_data.length;
  assign status      = out_data.status;

endmodule

// ===== design/utf8ca_checker.sv =====
module utf8ca_checker import utf8ca_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] char_byte0,
  input logic [7:0] char_byte1,
  input logic [7:0] char_byte2,
  input logic [7:0] char_byte3,
  input logic [2:0] char_length,
  input logic [1:0] status
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(char_byte0) && $stable(char_byte1)
      && $stable(char_byte2) && $stable(char_byte3) && $stable(char_length)
      && $stable(status))
    else $error("stalled output word changed");

  // bad lead carries no bytes and zero length
  a_bad_lead: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_BAD_LEAD |-> char_length == 3'd0 && char_byte0 == 8'd0
      && char_byte1 == 8'd0 && char_byte2 == 8'd0 && char_byte3 == 8'd0)
    else $error("bad lead word not cleared");

  // a real character has a length matching its lead byte
  a_len_lead: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_BAD_LEAD |->
      char_length != 3'd0 && char_length == lead_length(char_byte0))
    else $error("length does not match lead byte");

  // unused byte slots are zero
  a_zero_tail: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_BAD_LEAD |->
      (char_length > 3'd1 || char_byte1 == 8'd0) &&
      (char_length > 3'd2 || char_byte2 == 8'd0) &&
      (char_length > 3'd3 || char_byte3 == 8'd0))
    else $error("unused byte slot not zero");

  // nothing comes out in the cycle after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind utf8_char_assembler utf8ca_checker u_utf8ca_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import utf8ca_pkg::*;

  localparam int unsigned RandomItems = 1400;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned MaxReported = 10;
  localparam int unsigned HoldCycles  = 120;
  localparam int unsigned TailCycles  = 20;

  // Tracks the open character and holds the words the block still owes.
  class utf8_scoreboard;
    logic [7:0]  open_bytes [4];
    logic [2:0]  open_len;
    logic [2:0]  open_seen;
    result_t     owed_chars [$];
    int unsigned errors;

    function void clear_char();
      foreach (open_bytes[i]) open_bytes[i] = 8'h00;
      open_len  = 3'd0;
      open_seen = 3'd0;
    endfunction

    // count of leading ones picks the length; 10xxxxxx and 11111xxx give 0
    function logic [2:0] lead_len(logic [7:0] b);
      if (!b[7]) return 3'd1;
      if (!b[6]) return 3'd0;
      if (!b[5]) return 3'd2;
      if (!b[4]) return 3'd3;
      if (!b[3]) return 3'd4;
      return 3'd0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MaxReported) $display("%0t ERROR: %s", $realtime, msg);
    endfunction

    function void note_byte(logic [7:0] b);
      result_t    r;
      logic [2:0] len;
      logic [7:0] outb [4];
      r = '0;
      if (open_len == 3'd0) begin
        len = lead_len(b);
        if (len == 3'd0) begin
          r.status = ST_BAD_LEAD;
          owed_chars.push_back(r);
          clear_char();
          return;
        end
        clear_char();
        open_bytes[0] = b;
        open_seen     = 3'd1;
        open_len      = len;
      end else begin
        open_bytes[open_seen[1:0]] = b;
        open_seen = open_seen + 3'd1;
      end
      if (open_seen < open_len) return;
      r.status = ST_OK;
      r.length = open_len;
      for (int i = 0; i < 4; i++) begin
        outb[i] = (i < open_len) ? open_bytes[i] : 8'h00;
        if (i > 0 && i < open_len && open_bytes[i][7:6] != 2'b10) r.status = ST_BAD_CONT;
      end
      r.byte0 = outb[0];
      r.byte1 = outb[1];
      r.byte2 = outb[2];
      r.byte3 = outb[3];
      owed_chars.push_back(r);
      clear_char();
    endfunction

    function void check_char(result_t got);
      result_t want;
      if (owed_chars.size() == 0) begin
        report($sformatf("unexpected word %h %h %h %h len %0d status %0d",
                         got.byte0, got.byte1, got.byte2, got.byte3,
                         got.length, got.status));
        return;
      end
      want = owed_chars.pop_front();
      if (got.byte0 !== want.byte0 || got.byte1 !== want.byte1 ||
          got.byte2 !== want.byte2 || got.byte3 !== want.byte3 ||
          got.length !== want.length || got.status !== want.status)
        report($sformatf("exp %h %h %h %h len %0d st %0d, got %h %h %h %h len %0d st %0d",
                         want.byte0, want.byte1, want.byte2, want.byte3,
                         want.length, want.status,
                         got.byte0, got.byte1, got.byte2, got.byte3,
                         got.length, got.status));
    endfunction

    function int unsigned owed();
      return owed_chars.size();
    endfunction

    function void drain_check();
      if (owed_chars.size() != 0)
        report($sformatf("%0d words never arrived", owed_chars.size()));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] char_byte0, char_byte1, char_byte2, char_byte3;
  logic [2:0] char_length;
  logic [1:0] status;

  utf8_scoreboard sb = new;

  int unsigned cycles = 0;
  int unsigned sent_items = 0;
  bit          burst = 1'b0;   // no idling on either side while set
  int unsigned hold_asked = 0;
  int unsigned hold_granted = 0;
  int unsigned hold_left = 0;

  utf8_char_assembler dut (
    .clk, .rst,
    .in_valid, .in_stall, .in_byte,
    .out_valid, .out_stall,
    .char_byte0, .char_byte1, .char_byte2, .char_byte3,
    .char_length, .status
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_char({char_byte0, char_byte1, char_byte2, char_byte3, char_length, status});
  end

  // receiver: random stalls, plus one long hold-off when the sender asks
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else if (hold_granted != hold_asked) begin
        hold_granted = hold_asked;
        hold_left = HoldCycles - 1;
        out_stall <= 1'b1;
      end else if (burst) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 15);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_byte(input logic [7:0] b);
    if (!burst && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
    sent_items++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(99) < 8) return 8'($urandom_range(255));
    return {2'b10, 6'($urandom_range(63))};
  endfunction

  task automatic send_random_char();
    int unsigned len;
    int unsigned n;
    len = $urandom_range(1, 4);
    case (len)
      1: send_byte({1'b0, 7'($urandom_range(127))});
      2: send_byte({3'b110, 5'($urandom_range(31))});
      3: send_byte({4'b1110, 4'($urandom_range(15))});
      default: send_byte({5'b11110, 3'($urandom_range(7))});
    endcase
    // occasionally cut the character short; the next lead lands as a continuation
    n = ($urandom_range(99) < 5) ? $urandom_range(0, len - 1) : len;
    for (int i = 1; i < n; i++) send_byte(cont_byte());
  endtask

  logic [7:0] directed_bytes [$] = '{
    8'h00, 8'h7F,                       // single-byte extremes
    8'h80, 8'hBF, 8'hF8, 8'hFF,         // bad leads
    8'hC2, 8'h80,
    8'hEF, 8'hBF, 8'hBF,
    8'hF4, 8'h8F, 8'hBF, 8'hBF,
    8'hC3, 8'h41,                       // ASCII in place of a continuation
    8'hE2, 8'hC0, 8'hAC,                // lead-form byte mid-character
    8'hF0, 8'h9F, 8'h98, 8'hFF          // bad final byte
  };

  initial begin
    sb.clear_char();
    sb.errors = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    sent_items = 0;
    while (sent_items < RandomItems) begin
      if (hold_asked == 0 && sent_items >= 300) hold_asked = 1;
      if (sent_items >= 700 && sent_items < 705) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.owed() != 0) @(negedge clk);
        sent_items = 705;
      end
      burst = (sent_items >= 900 && sent_items < 1100);
      if ($urandom_range(99) < 12) send_byte(8'($urandom_range(255)));
      else send_random_char();
    end
    burst = 1'b0;
    in_valid <= 1'b0;

    while (sb.owed() != 0) @(negedge clk);
    repeat (TailCycles) @(negedge clk);
    sb.drain_check();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
